// File: src/sst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sprint start/stop timer.
// Depends on nothing; every module of the timer imports it.
package sst_pkg;

  typedef logic [1:0] phase_t;
  typedef logic [3:0] digit_t;
  typedef logic [7:0] char_t;
  typedef logic [1:0] beat_t;

  // Race phases.
  localparam phase_t PH_WAIT    = 2'd0;
  localparam phase_t PH_GREEN   = 2'd1;
  localparam phase_t PH_TIMING  = 2'd2;
  localparam phase_t PH_STOPPED = 2'd3;

  // Position within the four-character time report.
  localparam beat_t BEAT_SEC = 2'd0;
  localparam beat_t BEAT_DOT = 2'd1;
  localparam beat_t BEAT_TEN = 2'd2;
  localparam beat_t BEAT_HUN = 2'd3;

  localparam digit_t DIGIT_WRAP = 4'd10;
  localparam digit_t DIGIT_MAX  = 4'd9;

  localparam char_t ASCII_ZERO = 8'h30;
  localparam char_t ASCII_DOT  = 8'h2E;

  localparam logic [7:0] STOP_CONFIRM_RESET = 8'd10;

  // Everything the output stage needs to present the result of one tick.
  typedef struct packed {
    phase_t phase;
    logic   report;
    digit_t sec;
    digit_t ten;
    digit_t hun;
  } sst_result_t;

endpackage

// File: src/sst_bcd_step.sv
`timescale 1ns / 1ps
// Three-digit BCD time counter step with the finish-time trim on tenths.
// Depends on sst_pkg.
module sst_bcd_step (
  input  logic            advance,
  input  logic            trim,
  input  sst_pkg::digit_t hun,
  input  sst_pkg::digit_t ten,
  input  sst_pkg::digit_t sec,
  output sst_pkg::digit_t hun_next,
  output sst_pkg::digit_t ten_next,
  output sst_pkg::digit_t sec_next
);
  import sst_pkg::*;

  digit_t h_inc;
  digit_t t_inc;
  digit_t s_inc;
  digit_t t_cnt;
  logic   h_wrap;
  logic   t_wrap;

  always_comb begin
    h_inc  = hun + 4'd1;
    h_wrap = (h_inc == DIGIT_WRAP);
    t_inc  = ten + {3'd0, h_wrap};
    t_wrap = (t_inc == DIGIT_WRAP);
    s_inc  = sec + {3'd0, t_wrap};

    if (advance) begin
      hun_next = h_wrap ? 4'd0 : h_inc;
      t_cnt    = t_wrap ? 4'd0 : t_inc;
      sec_next = (s_inc == DIGIT_WRAP) ? 4'd0 : s_inc;
    end else begin
      hun_next = hun;
      t_cnt    = ten;
      sec_next = sec;
    end

    // The stop reading takes one tenth off, without borrowing from seconds.
    if (trim) begin
      ten_next = (t_cnt != 4'd0) ? t_cnt - 4'd1 : DIGIT_MAX;
    end else begin
      ten_next = t_cnt;
    end
  end

endmodule

// File: src/sst_report_out.sv
`timescale 1ns / 1ps
// Output register of the timer: lamp states and the serialized time report.
// Depends on sst_pkg.
module sst_report_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sst_pkg::sst_result_t load_data,
  output logic                load_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_green_lamp,
  output logic                out_yellow_lamp,
  output logic                out_red_lamp,
  output logic                out_char_valid,
  output logic [7:0]          out_tx_char,
  output logic                out_last
);
  import sst_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  sst_result_t data_r;
  beat_t       beat_r;
  beat_t       beat_nxt;
  logic        beat_done;

  assign out_valid       = valid_r;
  assign out_green_lamp  = (data_r.phase == PH_GREEN);
  assign out_yellow_lamp = (data_r.phase == PH_TIMING);
  assign out_red_lamp    = (data_r.phase == PH_STOPPED);
  assign out_char_valid  = data_r.report;
  assign out_last        = !data_r.report || (beat_r == BEAT_HUN);

  always_comb begin
    out_tx_char = 8'd0;
    if (data_r.report) begin
      unique case (beat_r)
        BEAT_SEC: out_tx_char = ASCII_ZERO + {4'd0, data_r.sec};
        BEAT_DOT: out_tx_char = ASCII_DOT;
        BEAT_TEN: out_tx_char = ASCII_ZERO + {4'd0, data_r.ten};
        BEAT_HUN: out_tx_char = ASCII_ZERO + {4'd0, data_r.hun};
        default:  out_tx_char = 8'd0;
      endcase
    end
  end

  assign beat_done = valid_r && !out_stall;
  assign load_free = !valid_r || (beat_done && out_last);

  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    if (load) begin
      valid_nxt = 1'b1;
      beat_nxt  = BEAT_SEC;
    end else if (beat_done) begin
      if (out_last) begin
        valid_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= BEAT_SEC;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  // Only a report walks past its first beat.
  a_beat_only_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (beat_r != BEAT_SEC) |-> data_r.report)
    else $error("report beat advanced on a lamp-only result");

  // A report is only ever produced by the stopping tick.
  a_report_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && data_r.report |-> data_r.phase == PH_STOPPED)
    else $error("time report without the stopped phase");

  // The final beat empties the stage unless a new result is loaded.
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    beat_done && out_last && !load |=> !valid_r)
    else $error("output stage stayed full after its final beat");

  // A new result never overwrites one that still has beats to deliver.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load && valid_r |-> beat_done && out_last)
    else $error("output stage loaded while busy");

endmodule

// File: src/sprint_start_stop_timer.sv
`timescale 1ns / 1ps
// Top level of the sprint start/stop timer.
// Depends on sst_pkg, sst_bcd_step and sst_report_out.

// The timer takes one tick per beat on the in_ channel: a sample tick (mode 0)
// feeds the start-block level into a ring of SAMPLE_WINDOW samples, and a
// hundredth tick (mode 1) advances the BCD race time while timing runs. Every
// tick yields one out_ beat with the lamp states; the tick that confirms the
// finish yields four beats instead, carrying the ASCII report "s.th", with
// out_last set on the final one. An accepted tick sits in an input register,
// is processed in a single pass into the output register, and while out_stall
// stays low a new tick can be accepted in every cycle, so the sustained rate
// is one tick per cycle. The finishing tick is the exception: its four report
// beats occupy the output register one after another, and in_stall rises
// during them only if a further tick is already waiting. The stop threshold
// is written through the cfg_ port, which is always ready and should only be
// written while idle.
module sprint_start_stop_timer #(
  parameter int unsigned SAMPLE_WINDOW = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic       in_start_level,
  input  logic       in_beam_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_green_lamp,
  output logic       out_yellow_lamp,
  output logic       out_red_lamp,
  output logic       out_char_valid,
  output logic [7:0] out_tx_char,
  output logic       out_last
);
  import sst_pkg::*;

  localparam int unsigned SLOT_W = (SAMPLE_WINDOW > 1) ? $clog2(SAMPLE_WINDOW) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLE_WINDOW - 1);

  // Configuration register: the beam must be seen broken this many times.
  logic [7:0] stop_confirm_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_confirm_r <= STOP_CONFIRM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stop_confirm_r <= cfg_data;
    end
  end

  // Input register. It frees up as soon as its tick moves to the output stage.
  logic hold_valid_r;
  logic hold_valid_nxt;
  logic hold_mode_r;
  logic hold_start_r;
  logic hold_beam_r;
  logic in_accept;
  logic load_free;
  logic advance;

  assign advance   = hold_valid_r && load_free;
  assign in_stall  = hold_valid_r && !load_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_accept) begin
      hold_valid_nxt = 1'b1;
    end else if (advance) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_mode_r  <= in_mode;
      hold_start_r <= in_start_level;
      hold_beam_r  <= in_beam_level;
    end
  end

  // Race state.
  phase_t                   phase_r;
  phase_t                   phase_nxt;
  logic [SLOT_W-1:0]        slot_r;
  logic [SLOT_W-1:0]        slot_nxt;
  logic [SAMPLE_WINDOW-1:0] samples_r;
  logic [SAMPLE_WINDOW-1:0] samples_upd;
  logic [SAMPLE_WINDOW-1:0] samples_nxt;
  digit_t                   hun_r;
  digit_t                   ten_r;
  digit_t                   sec_r;
  digit_t                   hun_nxt;
  digit_t                   ten_nxt;
  digit_t                   sec_nxt;
  logic [7:0]               broken_r;
  logic [7:0]               broken_inc;
  logic [7:0]               broken_nxt;
  logic                     do_sample;
  logic                     do_time;
  logic                     do_stop;
  sst_result_t              result;

  assign do_sample = advance && !hold_mode_r &&
                     ((phase_r == PH_WAIT) || (phase_r == PH_GREEN));
  assign do_time   = advance && hold_mode_r && (phase_r == PH_TIMING);

  // The new sample replaces the oldest one in the ring.
  always_comb begin
    for (int i = 0; i < SAMPLE_WINDOW; i++) begin
      samples_upd[i] = (slot_r == SLOT_W'(i)) ? hold_start_r : samples_r[i];
    end
  end

  assign broken_inc = broken_r + 8'd1;
  assign do_stop    = do_time && !hold_beam_r && (broken_inc == stop_confirm_r);

  sst_bcd_step u_bcd (
    .advance  (do_time),
    .trim     (do_stop),
    .hun      (hun_r),
    .ten      (ten_r),
    .sec      (sec_r),
    .hun_next (hun_nxt),
    .ten_next (ten_nxt),
    .sec_next (sec_nxt)
  );

  always_comb begin
    phase_nxt   = phase_r;
    slot_nxt    = slot_r;
    samples_nxt = samples_r;
    broken_nxt  = broken_r;
    if (do_sample) begin
      samples_nxt = samples_upd;
      slot_nxt    = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
      // A steady start signal means the runner has left the block.
      if ((&samples_upd) || !(|samples_upd)) begin
        phase_nxt = PH_TIMING;
      end else begin
        phase_nxt = PH_GREEN;
      end
    end
    if (do_time && !hold_beam_r) begin
      broken_nxt = broken_inc;
    end
    if (do_stop) begin
      phase_nxt = PH_STOPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      slot_r    <= '0;
      samples_r <= {1'b1, {(SAMPLE_WINDOW - 1){1'b0}}};
      hun_r     <= 4'd0;
      ten_r     <= 4'd0;
      sec_r     <= 4'd0;
      broken_r  <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      slot_r    <= slot_nxt;
      samples_r <= samples_nxt;
      hun_r     <= hun_nxt;
      ten_r     <= ten_nxt;
      sec_r     <= sec_nxt;
      broken_r  <= broken_nxt;
    end
  end

  assign result.phase  = phase_nxt;
  assign result.report = do_stop;
  assign result.sec    = sec_nxt;
  assign result.ten    = ten_nxt;
  assign result.hun    = hun_nxt;

  sst_report_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (advance),
    .load_data       (result),
    .load_free       (load_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_green_lamp  (out_green_lamp),
    .out_yellow_lamp (out_yellow_lamp),
    .out_red_lamp    (out_red_lamp),
    .out_char_valid  (out_char_valid),
    .out_tx_char     (out_tx_char),
    .out_last        (out_last)
  );

  // Once stopped, the race stays stopped until reset.
  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOPPED |=> phase_r == PH_STOPPED)
    else $error("timer left the stopped phase");

  // The time digits only move while timing runs.
  a_digits_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_TIMING |=> $stable(hun_r) && $stable(sec_r))
    else $error("time digits moved outside timing");

  // Timing can only start from a sample tick.
  a_start_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT || phase_r == PH_GREEN) && phase_nxt == PH_TIMING |-> do_sample)
    else $error("timing started without a sample tick");

endmodule
